// File: design/vnta_pkg.sv
// Shared types, constants and fixed-point helpers for the vertex normal and
// tangent accumulator. No dependencies; every other design file but vnta_ram imports it.
package vnta_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_UVS      = 1024;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int UIDX_W       = $clog2(MAX_UVS);
   localparam int VCNT_W       = VIDX_W + 1;
   localparam int UCNT_W       = UIDX_W + 1;

   localparam logic [2:0] OP_LOAD_VERTEX = 3'd0;
   localparam logic [2:0] OP_LOAD_UV     = 3'd1;
   localparam logic [2:0] OP_TRIANGLE    = 3'd2;
   localparam logic [2:0] OP_READ_VERTEX = 3'd3;
   localparam logic [2:0] OP_CLEAR       = 3'd4;

   localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
   localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [9:0]         vert_a;
      logic [9:0]         vert_b;
      logic [9:0]         vert_c;
      logic [9:0]         uv_a;
      logic [9:0]         uv_b;
      logic [9:0]         uv_c;
      logic               uv_present;
   } req_type;

   typedef struct packed {
      logic signed [31:0] smooth_nx;
      logic signed [31:0] smooth_ny;
      logic signed [31:0] smooth_nz;
      logic signed [31:0] face_nx;
      logic signed [31:0] face_ny;
      logic signed [31:0] face_nz;
      logic signed [31:0] tangent_x;
      logic signed [31:0] tangent_y;
      logic signed [31:0] tangent_z;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec3_type;

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
   } uv_type;

   typedef enum logic {
      DS_SQRT,
      DS_DIV
   } ds_mode_type;

   typedef struct packed {
      logic        start;
      ds_mode_type mode;
      logic [63:0] opa;
      logic [63:0] opb;
   } ds_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } ds_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_READ,
      S_READ_OUT,
      S_TRI_CHECK,
      S_POS,
      S_UV,
      S_MUL,
      S_MAX,
      S_SHR,
      S_MAX2,
      S_DBL,
      S_SQ,
      S_SQRT,
      S_SQRT_WAIT,
      S_NDIV,
      S_NDIV_WAIT,
      S_TDIV,
      S_TDIV_WAIT,
      S_UPDATE
   } seq_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? Q_MIN : Q_MAX;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat32({a[31], a} + {b[31], b});
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat32({a[31], a} - {b[31], b});
   endfunction

   // magnitude is at most 2^31
   function automatic logic signed [31:0] apply_sign(input logic neg, input logic [31:0] m);
      if (neg) begin
         return m[31] ? Q_MIN : -$signed(m);
      end
      return (m >= 32'h7fff_ffff) ? Q_MAX : $signed(m);
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic [63:0] mag65(input logic signed [64:0] x);
      logic [64:0] m;
      m = x[64] ? 65'(-x) : 65'(x);
      return m[63:0];
   endfunction

endpackage

// File: design/vnta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vnta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: design/vnta_mul.sv
// Shared 32x32 signed multiplier with a registered product.
// Depends on vnta_pkg only for the house import convention.
module vnta_mul import vnta_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// File: design/vnta_divsqrt.sv
// Iterative divide / square-root unit, one result bit per cycle on a shared
// 65-bit subtractor. Depends on vnta_pkg (ds_cmd_type, ds_rsp_type).
module vnta_divsqrt import vnta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  ds_cmd_type cmd,
   output ds_rsp_type rsp
);

   localparam logic [4:0] SQRT_ITERS = 5'd31;
   localparam logic [4:0] DIV_ITERS  = 5'd30;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   ds_mode_type mode_ff, mode_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] aux_ff, aux_in;
   logic [30:0] sh_ff, sh_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [64:0] sub_a, sub_b;
   logic [65:0] diff;
   logic        ge;

   always_comb begin
      if (mode_ff == DS_SQRT) begin
         sub_a = rem_ff;
         sub_b = {1'b0, acc_ff} + {1'b0, aux_ff};
      end else begin
         sub_a = {rem_ff[63:0], sh_ff[30]};
         sub_b = {1'b0, aux_ff};
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[65];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      aux_in  = aux_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (cmd.start) begin
            mode_in = cmd.mode;
            if (cmd.mode == DS_SQRT) begin
               rem_in  = {1'b0, cmd.opa};
               acc_in  = '0;
               aux_in  = 64'h4000_0000_0000_0000;
               cnt_in  = SQRT_ITERS;
               busy_in = 1'b1;
            end else if ({15'b0, cmd.opa[63:15]} >= cmd.opb) begin
               // quotient would reach 2^31
               acc_in  = 64'h0000_0000_8000_0000;
               done_in = 1'b1;
            end else begin
               rem_in  = {16'b0, cmd.opa[63:15]};
               sh_in   = {cmd.opa[14:0], 16'b0};
               acc_in  = '0;
               aux_in  = cmd.opb;
               cnt_in  = DIV_ITERS;
               busy_in = 1'b1;
            end
         end
      end else begin
         if (mode_ff == DS_SQRT) begin
            if (ge) begin
               rem_in = diff[64:0];
               acc_in = (acc_ff >> 1) + aux_ff;
            end else begin
               acc_in = acc_ff >> 1;
            end
            aux_in = aux_ff >> 2;
         end else begin
            rem_in = ge ? diff[64:0] : sub_a;
            acc_in = {acc_ff[62:0], ge};
            sh_in  = {sh_ff[29:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= DS_SQRT;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff[31:0];

endmodule

// File: design/vertex_normal_tangent_accumulator_unit.sv
// Vertex normal and tangent accumulator, signed Q16.16. Loads, clears and unused operations
// are done in the cycle in which they are taken; a read passes through S_READ and S_READ_OUT,
// where a stalled earlier response holds it, and its result is registered for the response.
// A triangle with an index out of range is dropped in S_TRI_CHECK. Otherwise its run time is
// set by the shared divide / square-root unit (one result bit per cycle: for a nonzero normal
// one square root and three normal divides, and with uv and a nonzero determinant three
// tangent divides) and by the one-bit-per-cycle normalizing shift of the cross product. One
// item is in work at a time. No clearing pass follows reset; accumulators are zeroed when
// their vertex is loaded.
module vertex_normal_tangent_accumulator_unit import vnta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [3:0] MUL_LAST_NRM = 4'd6;
   localparam logic [3:0] MUL_LAST_TAN = 4'd14;

   seq_state_type state_ff, state_in;
   logic [3:0]    step_ff, step_in;
   logic [VCNT_W-1:0] vcount_ff;
   logic [UCNT_W-1:0] ucount_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   req_type       req_ff;

   vec3_type p0_ff, e1_ff, e2_ff;
   uv_type   uv0_ff;
   logic signed [31:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [63:0] hold_ff, det_ff;
   logic signed [63:0] cr_ff [3];
   logic signed [64:0] num_ff [3];
   logic [63:0]        m_ff, sq_ff;
   logic [31:0]        len_ff;
   logic signed [31:0] nrm_ff [3];
   logic signed [31:0] tg_ff [3];

   logic req_accept, load_vtx, load_uv, tri_in_range, tan_ok, rsp_load, upd_wr;
   logic [63:0] max_mag;
   logic [1:0]  sel;
   logic [3:0]  mul_last, pj;

   logic                    pos_rd_en, uv_rd_en, acc_rd_en;
   logic [VIDX_W-1:0]       pos_rd_addr, acc_rd_addr, acc_wr_addr;
   logic [UIDX_W-1:0]       uv_rd_addr;
   logic [95:0]             pos_rd, smooth_rd, face_rd, tangent_rd;
   logic [63:0]             uv_rd;
   logic                    smooth_we, tangent_we;
   vec3_type                smooth_wd, face_wd, tangent_wd, s_old, t_old;
   uv_type                  uv_wd;
   vec3_type                pos_a, pos_b;
   uv_type                  uv_b;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   ds_cmd_type ds_cmd;
   ds_rsp_type ds_rsp;

   function automatic logic [VIDX_W-1:0] pick_vert(input req_type r, input logic [1:0] s);
      case (s)
         2'd0:    return VIDX_W'(r.vert_a);
         2'd1:    return VIDX_W'(r.vert_b);
         default: return VIDX_W'(r.vert_c);
      endcase
   endfunction

   function automatic logic [UIDX_W-1:0] pick_uv(input req_type r, input logic [1:0] s);
      case (s)
         2'd0:    return UIDX_W'(r.uv_a);
         2'd1:    return UIDX_W'(r.uv_b);
         default: return UIDX_W'(r.uv_c);
      endcase
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign load_vtx   = req_accept && (req_data.operation == OP_LOAD_VERTEX)
                       && (32'(vcount_ff) < MAX_VERTICES);
   assign load_uv    = req_accept && (req_data.operation == OP_LOAD_UV)
                       && (32'(ucount_ff) < MAX_UVS);
   assign sel        = step_ff[1:0];
   assign mul_last   = req_ff.uv_present ? MUL_LAST_TAN : MUL_LAST_NRM;
   assign tan_ok     = req_ff.uv_present && (det_ff != '0);
   assign pj         = step_ff - 4'd1;

   always_comb begin
      tri_in_range = (32'(req_ff.vert_a) < 32'(vcount_ff))
                  && (32'(req_ff.vert_b) < 32'(vcount_ff))
                  && (32'(req_ff.vert_c) < 32'(vcount_ff));
      if (req_ff.uv_present) begin
         tri_in_range = tri_in_range
                     && (32'(req_ff.uv_a) < 32'(ucount_ff))
                     && (32'(req_ff.uv_b) < 32'(ucount_ff))
                     && (32'(req_ff.uv_c) < 32'(ucount_ff));
      end
   end

   always_comb begin
      logic [63:0] m0, m1, m2;
      m0 = mag64(cr_ff[0]);
      m1 = mag64(cr_ff[1]);
      m2 = mag64(cr_ff[2]);
      max_mag = (m0 > m1) ? m0 : m1;
      max_mag = (m2 > max_mag) ? m2 : max_mag;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_accept) begin
               case (req_data.operation)
                  OP_TRIANGLE:    state_in = S_TRI_CHECK;
                  OP_READ_VERTEX: state_in = S_READ;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_READ:      state_in = S_READ_OUT;
         S_READ_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         S_TRI_CHECK: state_in = tri_in_range ? S_POS : S_IDLE;
         S_POS: begin
            if (step_ff == 4'd3) begin
               step_in  = '0;
               state_in = req_ff.uv_present ? S_UV : S_MUL;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_UV: begin
            if (step_ff == 4'd3) begin
               step_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_MUL: begin
            if (step_ff == mul_last) begin
               step_in  = '0;
               state_in = S_MAX;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_MAX: begin
            if (max_mag == '0) begin
               state_in = tan_ok ? S_TDIV : S_UPDATE;
            end else begin
               state_in = S_SHR;
            end
         end
         S_SHR: begin
            if (m_ff[63:30] == '0) begin
               state_in = S_MAX2;
            end
         end
         S_MAX2: state_in = S_DBL;
         S_DBL: begin
            if (m_ff[63:29] != '0) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (step_ff == 4'd3) begin
               step_in  = '0;
               state_in = S_SQRT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_SQRT: state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: begin
            if (ds_rsp.done) begin
               state_in = S_NDIV;
            end
         end
         S_NDIV: state_in = S_NDIV_WAIT;
         S_NDIV_WAIT: begin
            if (ds_rsp.done) begin
               if (step_ff == 4'd2) begin
                  step_in  = '0;
                  state_in = tan_ok ? S_TDIV : S_UPDATE;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_NDIV;
               end
            end
         end
         S_TDIV: state_in = S_TDIV_WAIT;
         S_TDIV_WAIT: begin
            if (ds_rsp.done) begin
               if (step_ff == 4'd2) begin
                  step_in  = '0;
                  state_in = S_UPDATE;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_TDIV;
               end
            end
         end
         S_UPDATE: begin
            if (step_ff == 4'd5) begin
               step_in  = '0;
               state_in = S_IDLE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      pos_rd_en   = 1'b0;
      pos_rd_addr = '0;
      uv_rd_en    = 1'b0;
      uv_rd_addr  = '0;
      acc_rd_en   = 1'b0;
      acc_rd_addr = '0;
      upd_wr      = 1'b0;
      rsp_load    = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      ds_cmd      = '0;
      case (state_ff)
         S_READ: begin
            acc_rd_en   = 1'b1;
            acc_rd_addr = VIDX_W'(req_ff.vert_a);
         end
         S_READ_OUT: rsp_load = !rsp_valid_ff || !rsp_stall;
         S_POS: begin
            pos_rd_en   = (step_ff != 4'd3);
            pos_rd_addr = pick_vert(req_ff, sel);
         end
         S_UV: begin
            uv_rd_en   = (step_ff != 4'd3);
            uv_rd_addr = pick_uv(req_ff, sel);
         end
         S_MUL: begin
            case (step_ff)
               4'd0:  begin mul_a = e1_ff.y; mul_b = e2_ff.z; end
               4'd1:  begin mul_a = e1_ff.z; mul_b = e2_ff.y; end
               4'd2:  begin mul_a = e1_ff.z; mul_b = e2_ff.x; end
               4'd3:  begin mul_a = e1_ff.x; mul_b = e2_ff.z; end
               4'd4:  begin mul_a = e1_ff.x; mul_b = e2_ff.y; end
               4'd5:  begin mul_a = e1_ff.y; mul_b = e2_ff.x; end
               4'd6:  begin mul_a = du2_ff;  mul_b = dv1_ff;  end
               4'd7:  begin mul_a = du1_ff;  mul_b = dv2_ff;  end
               4'd8:  begin mul_a = e1_ff.x; mul_b = dv1_ff;  end
               4'd9:  begin mul_a = e2_ff.x; mul_b = dv2_ff;  end
               4'd10: begin mul_a = e1_ff.y; mul_b = dv1_ff;  end
               4'd11: begin mul_a = e2_ff.y; mul_b = dv2_ff;  end
               4'd12: begin mul_a = e1_ff.z; mul_b = dv1_ff;  end
               4'd13: begin mul_a = e2_ff.z; mul_b = dv2_ff;  end
               default: ;
            endcase
         end
         S_SQ: begin
            if (step_ff != 4'd3) begin
               mul_a = cr_ff[sel][31:0];
               mul_b = cr_ff[sel][31:0];
            end
         end
         S_SQRT: begin
            ds_cmd.start = 1'b1;
            ds_cmd.mode  = DS_SQRT;
            ds_cmd.opa   = sq_ff;
         end
         S_NDIV: begin
            ds_cmd.start = 1'b1;
            ds_cmd.mode  = DS_DIV;
            ds_cmd.opa   = mag64(cr_ff[sel]);
            ds_cmd.opb   = {32'b0, len_ff};
         end
         S_TDIV: begin
            ds_cmd.start = 1'b1;
            ds_cmd.mode  = DS_DIV;
            ds_cmd.opa   = mag65(num_ff[sel]);
            ds_cmd.opb   = mag64(det_ff);
         end
         S_UPDATE: begin
            acc_rd_addr = pick_vert(req_ff, step_ff[2:1]);
            acc_rd_en   = !step_ff[0];
            upd_wr      = step_ff[0];
         end
         default: ;
      endcase
   end

   // store write ports
   always_comb begin
      s_old        = smooth_rd;
      t_old        = tangent_rd;
      smooth_we    = load_vtx || upd_wr;
      tangent_we   = load_vtx || (upd_wr && tan_ok);
      acc_wr_addr  = upd_wr ? acc_rd_addr : VIDX_W'(vcount_ff);
      smooth_wd    = '0;
      face_wd      = '0;
      tangent_wd   = '0;
      if (upd_wr) begin
         smooth_wd.x  = sat_add(s_old.x, nrm_ff[0]);
         smooth_wd.y  = sat_add(s_old.y, nrm_ff[1]);
         smooth_wd.z  = sat_add(s_old.z, nrm_ff[2]);
         face_wd.x    = nrm_ff[0];
         face_wd.y    = nrm_ff[1];
         face_wd.z    = nrm_ff[2];
         tangent_wd.x = sat_add(t_old.x, tg_ff[0]);
         tangent_wd.y = sat_add(t_old.y, tg_ff[1]);
         tangent_wd.z = sat_add(t_old.z, tg_ff[2]);
      end
      uv_wd.u = req_data.coord_x;
      uv_wd.v = sat32(ONE_Q16 - {req_data.coord_y[31], req_data.coord_y});
   end

   vnta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (load_vtx),
      .wr_addr (VIDX_W'(vcount_ff)),
      .wr_data ({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
      .rd_en   (pos_rd_en),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd)
   );

   vnta_ram #(.WIDTH(64), .DEPTH(MAX_UVS)) u_uv_ram (
      .clock   (clock),
      .wr_en   (load_uv),
      .wr_addr (UIDX_W'(ucount_ff)),
      .wr_data (uv_wd),
      .rd_en   (uv_rd_en),
      .rd_addr (uv_rd_addr),
      .rd_data (uv_rd)
   );

   vnta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_smooth_ram (
      .clock   (clock),
      .wr_en   (smooth_we),
      .wr_addr (acc_wr_addr),
      .wr_data (smooth_wd),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (smooth_rd)
   );

   vnta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_face_ram (
      .clock   (clock),
      .wr_en   (smooth_we),
      .wr_addr (acc_wr_addr),
      .wr_data (face_wd),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (face_rd)
   );

   vnta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_tangent_ram (
      .clock   (clock),
      .wr_en   (tangent_we),
      .wr_addr (acc_wr_addr),
      .wr_data (tangent_wd),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (tangent_rd)
   );

   vnta_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   vnta_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (ds_cmd),
      .rsp   (ds_rsp)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         vcount_ff    <= '0;
         ucount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= (rsp_valid_ff && rsp_stall) || rsp_load;
         if (load_vtx) begin
            vcount_ff <= vcount_ff + VCNT_W'(1);
         end
         if (load_uv) begin
            ucount_ff <= ucount_ff + UCNT_W'(1);
         end
         if (req_accept && (req_data.operation == OP_CLEAR)) begin
            vcount_ff <= '0;
            ucount_ff <= '0;
         end
      end
   end

   assign pos_a = pos_rd;
   assign pos_b = p0_ff;
   assign uv_b  = uv_rd;

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         if (32'(req_ff.vert_a) < 32'(vcount_ff)) begin
            rsp_data_ff <= {smooth_rd, face_rd, tangent_rd};
         end else begin
            rsp_data_ff <= '0;
         end
      end
      case (state_ff)
         S_POS: begin
            case (step_ff)
               4'd1: p0_ff <= pos_rd;
               4'd2: begin
                  e1_ff.x <= sat_sub(pos_b.x, pos_a.x);
                  e1_ff.y <= sat_sub(pos_b.y, pos_a.y);
                  e1_ff.z <= sat_sub(pos_b.z, pos_a.z);
               end
               4'd3: begin
                  e2_ff.x <= sat_sub(pos_b.x, pos_a.x);
                  e2_ff.y <= sat_sub(pos_b.y, pos_a.y);
                  e2_ff.z <= sat_sub(pos_b.z, pos_a.z);
               end
               default: ;
            endcase
         end
         S_UV: begin
            case (step_ff)
               4'd1: uv0_ff <= uv_rd;
               4'd2: begin
                  du1_ff <= sat_sub(uv_b.u, uv0_ff.u);
                  dv1_ff <= sat_sub(uv_b.v, uv0_ff.v);
               end
               4'd3: begin
                  du2_ff <= sat_sub(uv_b.u, uv0_ff.u);
                  dv2_ff <= sat_sub(uv_b.v, uv0_ff.v);
               end
               default: ;
            endcase
         end
         S_MUL: begin
            if (step_ff != '0) begin
               if (!pj[0]) begin
                  hold_ff <= prod;
               end else begin
                  case (pj[3:1])
                     3'd0: cr_ff[0] <= hold_ff - prod;
                     3'd1: cr_ff[1] <= hold_ff - prod;
                     3'd2: cr_ff[2] <= hold_ff - prod;
                     3'd3: det_ff   <= hold_ff - prod;
                     3'd4: num_ff[0] <= {hold_ff[63], hold_ff} + {prod[63], prod};
                     3'd5: num_ff[1] <= {hold_ff[63], hold_ff} + {prod[63], prod};
                     3'd6: num_ff[2] <= {hold_ff[63], hold_ff} + {prod[63], prod};
                     default: ;
                  endcase
               end
            end
         end
         S_MAX, S_MAX2: begin
            m_ff <= max_mag;
            if (max_mag == '0) begin
               nrm_ff[0] <= '0;
               nrm_ff[1] <= '0;
               nrm_ff[2] <= '0;
            end
         end
         S_SHR: begin
            if (m_ff[63:30] != '0) begin
               m_ff     <= m_ff >> 1;
               cr_ff[0] <= cr_ff[0] >>> 1;
               cr_ff[1] <= cr_ff[1] >>> 1;
               cr_ff[2] <= cr_ff[2] >>> 1;
            end
         end
         S_DBL: begin
            if (m_ff[63:29] == '0) begin
               m_ff     <= m_ff << 1;
               cr_ff[0] <= cr_ff[0] <<< 1;
               cr_ff[1] <= cr_ff[1] <<< 1;
               cr_ff[2] <= cr_ff[2] <<< 1;
            end
         end
         S_SQ: begin
            if (step_ff == 4'd1) begin
               sq_ff <= prod;
            end else if (step_ff != '0) begin
               sq_ff <= sq_ff + prod;
            end
         end
         S_SQRT_WAIT: begin
            if (ds_rsp.done) begin
               len_ff <= ds_rsp.result;
            end
         end
         S_NDIV_WAIT: begin
            if (ds_rsp.done) begin
               nrm_ff[sel] <= apply_sign(cr_ff[sel][63], ds_rsp.result);
            end
         end
         S_TDIV_WAIT: begin
            if (ds_rsp.done) begin
               tg_ff[sel] <= apply_sign(num_ff[sel][64] ^ det_ff[63], ds_rsp.result);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/vnta_checker.sv
// Port-level checker for the vertex normal and tangent accumulator, bound to
// the top level. Depends on vnta_pkg (req_type, rsp_type, operation codes).
module vnta_checker import vnta_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled response changed");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && (req_data.operation == OP_READ_VERTEX), 3))
      else $error("response without a read transaction");

   a_busy_after_long_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && ((req_data.operation == OP_TRIANGLE)
         || (req_data.operation == OP_READ_VERTEX)) |=> req_stall)
      else $error("new transaction taken during a multi-cycle operation");

endmodule

bind vertex_normal_tangent_accumulator_unit vnta_checker u_vnta_checker (.*);
